// ----- design/pmtu_pkg.sv -----
// Shared types and constants for the path MTU search controller.
`default_nettype none

package pmtu_pkg;

   // Field widths
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned BOUND_W = 18;
   localparam int unsigned CODE_W  = 8;

   // Default size limits per address family
   localparam int unsigned MIN_MTU_V4_DEF   = 68;
   localparam int unsigned MIN_MTU_V6_DEF   = 1280;
   localparam int unsigned MAX_DGRAM_V4_DEF = 65535;
   localparam int unsigned MAX_DGRAM_V6_DEF = 65535;

   // Reset value of the upper bound register
   localparam logic [LEN_W-1:0] UPPER_LIMIT_RST = 16'd1500;

   // ICMP / ICMPv6 message types and codes of interest
   localparam logic [7:0] ICMP4_ECHO_REPLY      = 8'd0;
   localparam logic [7:0] ICMP4_DEST_UNREACH    = 8'd3;
   localparam logic [7:0] ICMP4_TIME_EXCEEDED   = 8'd11;
   localparam logic [7:0] ICMP4_CODE_FRAG_NEED  = 8'd4;
   localparam logic [7:0] V6_TYPE_UNREACH       = 8'd1;
   localparam logic [7:0] V6_TYPE_TOO_BIG       = 8'd2;
   localparam logic [7:0] V6_TYPE_HOP_LIMIT     = 8'd3;
   localparam logic [7:0] V6_TYPE_ECHO_REPLY    = 8'd129;

   // Config register indexes
   typedef enum logic [1:0] {
      CSR_IPV6_MODE   = 2'd0,
      CSR_UPPER_LIMIT = 2'd1,
      CSR_PROBE_ID    = 2'd2
   } csr_index_type;

   // Event kinds on the request channel
   typedef enum logic [1:0] {
      EV_START         = 2'd0,
      EV_LOCAL_TOO_BIG = 2'd1,
      EV_TIMEOUT       = 2'd2,
      EV_REPLY         = 2'd3
   } event_type;

   // Classified reply (identifier already checked)
   typedef enum logic [2:0] {
      RK_IGNORE        = 3'd0,
      RK_ECHO4         = 3'd1,
      RK_FRAG_NEEDED   = 3'd2,
      RK_UNREACH       = 3'd3,
      RK_TIME_EXCEEDED = 3'd4,
      RK_ECHO6         = 3'd5,
      RK_TOO_BIG6      = 3'd6
   } reply_kind_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_PROBE         = 3'd0,
      ST_WAIT          = 3'd1,
      ST_DONE          = 3'd2,
      ST_BAD_LIMIT     = 3'd3,
      ST_NO_REPLY      = 3'd4,
      ST_UNREACH       = 3'd5,
      ST_TIME_EXCEEDED = 3'd6
   } status_type;

   // Classified command passed from front to back
   typedef struct packed {
      event_type          ev;
      logic               v6;
      reply_kind_type     kind;
      logic               limit_bad;
      logic [LEN_W-1:0]   upper;
      logic [LEN_W-1:0]   min_mtu;
      logic [CODE_W-1:0]  code;
      logic [LEN_W-1:0]   seq;
      logic [LEN_W-1:0]   next_hop_mtu;
   } cmd_type;

endpackage

`default_nettype wire

// ----- design/pmtu_front.sv -----
// Front end: config registers and event classification.
`default_nettype none

module pmtu_front #(
   parameter int unsigned MIN_MTU_V4   = 68,
   parameter int unsigned MIN_MTU_V6   = 1280,
   parameter int unsigned MAX_DGRAM_V4 = 65535,
   parameter int unsigned MAX_DGRAM_V6 = 65535
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_wdata,
   input  wire logic [1:0]            req_mode,
   input  wire logic [7:0]            req_icmp_type,
   input  wire logic [7:0]            req_icmp_code,
   input  wire logic [15:0]           req_echo_ident,
   input  wire logic [15:0]           req_echo_seq,
   input  wire logic [15:0]           req_next_hop_mtu,
   output pmtu_pkg::cmd_type          cmd
);
   import pmtu_pkg::*;

   localparam logic [LEN_W-1:0] MIN4 = LEN_W'(MIN_MTU_V4);
   localparam logic [LEN_W-1:0] MIN6 = LEN_W'(MIN_MTU_V6);
   localparam logic [LEN_W-1:0] MAX4 = LEN_W'(MAX_DGRAM_V4);
   localparam logic [LEN_W-1:0] MAX6 = LEN_W'(MAX_DGRAM_V6);

   logic              ipv6_mode_ff, ipv6_mode_in;
   logic [LEN_W-1:0]  upper_limit_ff, upper_limit_in;
   logic [LEN_W-1:0]  probe_id_ff, probe_id_in;
   logic [LEN_W-1:0]  min_mtu, max_dgram;
   reply_kind_type    kind;

   // Config register writes
   always_comb begin
      ipv6_mode_in   = ipv6_mode_ff;
      upper_limit_in = upper_limit_ff;
      probe_id_in    = probe_id_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_IPV6_MODE:   ipv6_mode_in   = csr_wdata[0];
            CSR_UPPER_LIMIT: upper_limit_in = csr_wdata;
            CSR_PROBE_ID:    probe_id_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv6_mode_ff   <= 1'b0;
         upper_limit_ff <= UPPER_LIMIT_RST;
         probe_id_ff    <= '0;
      end else begin
         ipv6_mode_ff   <= ipv6_mode_in;
         upper_limit_ff <= upper_limit_in;
         probe_id_ff    <= probe_id_in;
      end
   end

   assign min_mtu   = ipv6_mode_ff ? MIN6 : MIN4;
   assign max_dgram = ipv6_mode_ff ? MAX6 : MAX4;

   // Reply classification by family; a foreign identifier is ignored
   always_comb begin
      kind = RK_IGNORE;
      if (!ipv6_mode_ff) begin
         unique case (req_icmp_type)
            ICMP4_ECHO_REPLY:    kind = RK_ECHO4;
            ICMP4_DEST_UNREACH:  kind = (req_icmp_code == ICMP4_CODE_FRAG_NEED) ?
                                        RK_FRAG_NEEDED : RK_UNREACH;
            ICMP4_TIME_EXCEEDED: kind = RK_TIME_EXCEEDED;
            default:             kind = RK_IGNORE;
         endcase
      end else begin
         unique case (req_icmp_type)
            V6_TYPE_ECHO_REPLY:  kind = RK_ECHO6;
            V6_TYPE_TOO_BIG:     kind = RK_TOO_BIG6;
            V6_TYPE_HOP_LIMIT:   kind = RK_TIME_EXCEEDED;
            V6_TYPE_UNREACH:     kind = RK_UNREACH;
            default:             kind = RK_IGNORE;
         endcase
      end
      if (req_echo_ident != probe_id_ff) kind = RK_IGNORE;
   end

   // Build the command item
   always_comb begin
      cmd.ev           = event_type'(req_mode);
      cmd.v6           = ipv6_mode_ff;
      cmd.kind         = kind;
      cmd.limit_bad    = (upper_limit_ff > max_dgram) || (upper_limit_ff < min_mtu);
      cmd.upper        = upper_limit_ff;
      cmd.min_mtu      = min_mtu;
      cmd.code         = req_icmp_code;
      cmd.seq          = req_echo_seq;
      cmd.next_hop_mtu = req_next_hop_mtu;
   end

endmodule

`default_nettype wire

// ----- design/pmtu_cmd_fifo.sv -----
// Short command queue between front and back end.
`default_nettype none

module pmtu_cmd_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  pmtu_pkg::cmd_type      push_data,
   output logic                   full,
   input  wire logic              pop,
   output pmtu_pkg::cmd_type      pop_data,
   output logic                   valid
);
   import pmtu_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   cmd_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ----- design/pmtu_back.sv -----
// Back end: search state, bound updates and the result register.
`default_nettype none

module pmtu_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  pmtu_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output logic [2:0]             rsp_status,
   output logic [15:0]            rsp_probe_length,
   output logic [15:0]            rsp_probe_seq,
   output logic [15:0]            rsp_result_mtu,
   output logic [7:0]             rsp_error_code
);
   import pmtu_pkg::*;

   typedef enum logic [1:0] {
      ACT_ADVANCE = 2'd0,
      ACT_WAIT    = 2'd1,
      ACT_FAIL    = 2'd2,
      ACT_DONE    = 2'd3
   } action_type;

   logic [BOUND_W-1:0] low_ff, low_in;
   logic [BOUND_W-1:0] high_ff, high_in;
   logic [LEN_W-1:0]   seq_ff, seq_in;
   logic               tbs_ff, tbs_in;
   logic               search_ff, search_in;

   logic               out_valid_ff, out_valid_in;
   status_type         status_ff, status_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   pseq_ff, pseq_in;
   logic [LEN_W-1:0]   mtu_ff, mtu_in;
   logic [CODE_W-1:0]  code_ff, code_in;

   logic [BOUND_W:0]   sum_cur, sum_new;
   logic [BOUND_W-1:0] mid_cur, mid_new, lowered, min_ext, nh_ext;
   action_type         act;
   status_type         fail_status;
   logic [CODE_W-1:0]  fail_code;
   logic [LEN_W-1:0]   done_mtu;
   logic               seq_match;

   assign cmd_pop   = cmd_valid && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;

   // Midpoint of the current bounds
   assign sum_cur = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid_cur = sum_cur[BOUND_W:1];
   assign lowered = (mid_cur != '0) ? mid_cur - 1'b1 : '0;
   assign min_ext = {{(BOUND_W-LEN_W){1'b0}}, cmd.min_mtu};
   assign nh_ext  = {{(BOUND_W-LEN_W){1'b0}}, cmd.next_hop_mtu};
   assign seq_match = (cmd.seq == seq_ff);

   // Event handling: new bounds and the kind of answer
   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      tbs_in      = tbs_ff;
      search_in   = search_ff;
      act         = ACT_WAIT;
      fail_status = ST_UNREACH;
      fail_code   = '0;
      done_mtu    = '0;
      if (cmd.ev == EV_START) begin
         low_in = min_ext;
         high_in = {{(BOUND_W-LEN_W){1'b0}}, cmd.upper};
         tbs_in = 1'b0;
         if (cmd.limit_bad) begin
            search_in   = 1'b0;
            act         = ACT_FAIL;
            fail_status = ST_BAD_LIMIT;
         end else begin
            search_in = 1'b1;
            act       = ACT_ADVANCE;
         end
      end else if (search_ff) begin
         unique case (cmd.ev)
            EV_LOCAL_TOO_BIG: begin
               if (!cmd.v6) begin
                  high_in = lowered;
                  act     = ACT_ADVANCE;
               end
            end
            EV_TIMEOUT: begin
               if (high_ff <= min_ext + 1'b1) begin
                  search_in   = 1'b0;
                  act         = ACT_FAIL;
                  fail_status = ST_UNREACH;
               end else begin
                  high_in = lowered;
                  tbs_in  = 1'b0;
                  act     = ACT_ADVANCE;
               end
            end
            EV_REPLY: begin
               if (seq_match) begin
                  unique case (cmd.kind)
                     RK_ECHO4: begin
                        low_in = mid_cur + 1'b1;
                        act    = ACT_ADVANCE;
                     end
                     RK_FRAG_NEEDED: begin
                        high_in = lowered;
                        act     = ACT_ADVANCE;
                     end
                     RK_UNREACH: begin
                        search_in   = 1'b0;
                        act         = ACT_FAIL;
                        fail_status = ST_UNREACH;
                        fail_code   = cmd.code;
                     end
                     RK_TIME_EXCEEDED: begin
                        search_in   = 1'b0;
                        act         = ACT_FAIL;
                        fail_status = ST_TIME_EXCEEDED;
                        fail_code   = cmd.code;
                     end
                     RK_ECHO6: begin
                        if (tbs_ff) begin
                           search_in = 1'b0;
                           act       = ACT_DONE;
                           done_mtu  = mid_cur[LEN_W-1:0];
                        end else begin
                           low_in = mid_cur + 1'b1;
                           act    = ACT_ADVANCE;
                        end
                     end
                     RK_TOO_BIG6: begin
                        tbs_in = 1'b1;
                        if (nh_ext < low_ff) begin
                           high_in   = '0;
                           search_in = 1'b0;
                           act       = ACT_DONE;
                           done_mtu  = cmd.next_hop_mtu;
                        end else begin
                           high_in = {nh_ext[BOUND_W-2:0], 1'b0} - low_ff;
                           act     = ACT_ADVANCE;
                        end
                     end
                     default: act = ACT_WAIT;
                  endcase
               end
            end
            default: act = ACT_WAIT;
         endcase
      end
   end

   // Midpoint of the updated bounds for the next probe
   assign sum_new = {1'b0, low_in} + {1'b0, high_in};
   assign mid_new = sum_new[BOUND_W:1];

   // Result item and sequence counter
   always_comb begin
      seq_in    = seq_ff;
      status_in = ST_WAIT;
      len_in    = '0;
      pseq_in   = '0;
      mtu_in    = '0;
      code_in   = '0;
      unique case (act)
         ACT_ADVANCE: begin
            if (high_in >= low_in) begin
               seq_in    = seq_ff + 1'b1;
               status_in = ST_PROBE;
               len_in    = mid_new[LEN_W-1:0];
               pseq_in   = seq_ff + 1'b1;
            end else begin
               status_in = ST_DONE;
               mtu_in    = mid_new[LEN_W-1:0];
            end
         end
         ACT_FAIL: begin
            status_in = fail_status;
            code_in   = fail_code;
         end
         ACT_DONE: begin
            status_in = ST_DONE;
            mtu_in    = done_mtu;
         end
         default: status_in = ST_WAIT;
      endcase
   end

   // Result register holds an item from execution until it is popped
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd_pop)      out_valid_in = 1'b1;
      else if (rsp_pop) out_valid_in = 1'b0;
   end

   // Search state registers, updated when an item executes; the search also ends when an advance finds crossed bounds
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         high_ff      <= '0;
         seq_ff       <= '0;
         tbs_ff       <= 1'b0;
         search_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd_pop) begin
            low_ff    <= low_in;
            high_ff   <= high_in;
            seq_ff    <= seq_in;
            tbs_ff    <= tbs_in;
            search_ff <= (act == ACT_ADVANCE && high_in < low_in) ? 1'b0 : search_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         status_ff <= status_in;
         len_ff    <= len_in;
         pseq_ff   <= pseq_in;
         mtu_ff    <= mtu_in;
         code_ff   <= code_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_probe_length = len_ff;
   assign rsp_probe_seq    = pseq_ff;
   assign rsp_result_mtu   = mtu_ff;
   assign rsp_error_code   = code_ff;

endmodule

`default_nettype wire

// ----- design/path_mtu_search_controller_core.sv -----
// Top level of the path MTU search controller.
//
// Usage: events enter on the req_ queue port (req_push / req_full) and are
// taken when req_push is high and req_full is low. Each event yields exactly
// one result on the rsp_ queue port; the oldest result is shown while
// rsp_empty is low and is taken when rsp_pop is high.
// Config registers (ipv6_mode, upper_limit, probe_id at indexes 0..2) are
// written through csr_wen / csr_index / csr_wdata; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// An accepted event is stored in the command queue, then executed by the
// back end into the result register. Throughput: one event per cycle while
// rsp_pop is high each cycle; a two-entry command queue sits between the
// classifier and the back end.
// When rsp_pop stays low, the result register holds, the command queue
// fills and req_full rises; nothing is lost.
// Reset (synchronous, active high) empties both queues, clears the search
// state to idle and restores the config registers to their defaults.
`default_nettype none

module path_mtu_search_controller_core #(
   parameter int unsigned MIN_MTU_V4   = pmtu_pkg::MIN_MTU_V4_DEF,
   parameter int unsigned MIN_MTU_V6   = pmtu_pkg::MIN_MTU_V6_DEF,
   parameter int unsigned MAX_DGRAM_V4 = pmtu_pkg::MAX_DGRAM_V4_DEF,
   parameter int unsigned MAX_DGRAM_V6 = pmtu_pkg::MAX_DGRAM_V6_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wen,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_wdata,
   input  wire logic         req_push,
   output logic              req_full,
   input  wire logic [1:0]   req_mode,
   input  wire logic [7:0]   req_icmp_type,
   input  wire logic [7:0]   req_icmp_code,
   input  wire logic [15:0]  req_echo_ident,
   input  wire logic [15:0]  req_echo_seq,
   input  wire logic [15:0]  req_next_hop_mtu,
   output logic              rsp_empty,
   input  wire logic         rsp_pop,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_probe_length,
   output logic [15:0]       rsp_probe_seq,
   output logic [15:0]       rsp_result_mtu,
   output logic [7:0]        rsp_error_code
);
   import pmtu_pkg::*;

   cmd_type  front_cmd;
   cmd_type  queue_cmd;
   logic     queue_valid;
   logic     back_pop;

   // Config and classification
   pmtu_front #(
      .MIN_MTU_V4   (MIN_MTU_V4),
      .MIN_MTU_V6   (MIN_MTU_V6),
      .MAX_DGRAM_V4 (MAX_DGRAM_V4),
      .MAX_DGRAM_V6 (MAX_DGRAM_V6)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_mode         (req_mode),
      .req_icmp_type    (req_icmp_type),
      .req_icmp_code    (req_icmp_code),
      .req_echo_ident   (req_echo_ident),
      .req_echo_seq     (req_echo_seq),
      .req_next_hop_mtu (req_next_hop_mtu),
      .cmd              (front_cmd)
   );

   // Command queue
   pmtu_cmd_fifo #(
      .DEPTH (2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (back_pop),
      .pop_data  (queue_cmd),
      .valid     (queue_valid)
   );

   // Search execution and result register
   pmtu_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (queue_valid),
      .cmd              (queue_cmd),
      .cmd_pop          (back_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_status       (rsp_status),
      .rsp_probe_length (rsp_probe_length),
      .rsp_probe_seq    (rsp_probe_seq),
      .rsp_result_mtu   (rsp_result_mtu),
      .rsp_error_code   (rsp_error_code)
   );

   // Back end only executes items that are queued
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      back_pop |-> queue_valid)
      else $error("back end consumed an item from an empty queue");

   // An executed item always lands in the result register
   a_exec_gives_result: assert property (@(posedge clock) disable iff (reset)
      back_pop |=> !rsp_empty)
      else $error("executed item produced no result");

   // A push into an empty queue is visible to the back end next cycle
   a_push_reaches_back: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && !queue_valid) |=> queue_valid)
      else $error("accepted item did not reach the command queue");

   // Nothing is offered in the first cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result shown right after reset");

endmodule

`default_nettype wire
